// ===== hw/rtl/crbd_pkg.sv =====
package crbd_pkg;

	// image limits
	parameter int MAX_WIDTH  = 2048;
	parameter int MAX_HEIGHT = 256;

	// port widths
	parameter int COL_W   = 11;
	parameter int ROW_W   = 8;
	parameter int WREG_W  = 12;
	parameter int HREG_W  = 9;
	parameter int CFG_W   = 12;
	parameter int GRP_W   = 16;
	parameter int CNT_W   = 3;
	parameter int PIX_W   = 4;
	parameter int LEN_W   = 8;
	parameter int GRP_PIX = 4;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	parameter logic [LEN_W-1:0] CODE_INVERT = 8'hFF;
	parameter logic [LEN_W-1:0] COPY_FLAG   = 8'h80;
	parameter logic [LEN_W-1:0] COPY_LEN    = 8'h7F;
	parameter logic [PIX_W-1:0] NIBBLE_MASK = 4'hF;

	parameter logic [WREG_W-1:0] WIDTH_RESET  = 12'd320;
	parameter logic [HREG_W-1:0] HEIGHT_RESET = 9'd128;

endpackage

// ===== hw/rtl/column_rle_backdrop_decoder_top.sv =====
// column-major run-length decoder for 4-bit images
// input channel (in_valid/in_stall): one coded byte per transaction, with
// image_start set on the first byte of an image to clear position and parse state.
// output channel (out_valid/out_stall): groups of up to four decoded pixels,
// with the column and row of the first pixel, a last_of_run mark on the
// final group of a byte and image_done on the group that closes the image.
// configuration (cfg_we/cfg_index/cfg_wdata): image width and height, written
// while no byte is in flight; out-of-range values are clamped on write.
// sequence: a byte is taken in ST_IDLE; each colour pixel then passes through
// ST_PIXEL and each copied pixel through ST_READ and ST_PIXEL (read of the
// left-column store, then the write), and each emitted group through ST_EMIT.
// a prefix byte, an empty run or a byte after the image end stays in ST_IDLE. the
// single pixel sequencer and the one-port left-column store set this order. in_stall is high while a byte is decoded.
// a finished group waits in the output register; while the receiver stalls the
// sequencer holds at the next group and the payload stays put.
// reset (arst_n low) clears the position, parse state, store valid bits and the
// output register, and loads width 320 and height 128.
module column_rle_backdrop_decoder_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [crbd_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  code_byte,
	input  logic                        image_start,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [crbd_pkg::GRP_W-1:0]  pixel_group,
	output logic [crbd_pkg::CNT_W-1:0]  pixel_count,
	output logic [crbd_pkg::COL_W-1:0]  start_column,
	output logic [crbd_pkg::ROW_W-1:0]  start_row,
	output logic                        last_of_run,
	output logic                        image_done
);
	import crbd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_PIXEL,
		ST_EMIT
	} state_t;

	localparam logic [WREG_W-1:0] MAX_W_V = WREG_W'(MAX_WIDTH);
	localparam logic [HREG_W-1:0] MAX_H_V = HREG_W'(MAX_HEIGHT);

	state_t               state_q;
	logic [WREG_W-1:0]    width_q;
	logic [HREG_W-1:0]    height_q;
	logic                 await_q;
	logic                 pend_copy_q;
	logic [PIX_W-1:0]     pend_colour_q;
	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic                 fin_q;
	logic [LEN_W-1:0]     len_q;
	logic                 copy_q;
	logic [PIX_W-1:0]     colour_q;
	logic [GRP_W-1:0]     grp_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [COL_W-1:0]     gcol_q;
	logic [ROW_W-1:0]     grow_q;
	logic                 emit_last_q;
	logic                 emit_done_q;
	logic [PIX_W-1:0]     rd_data_q;
	logic [MAX_HEIGHT-1:0] store_vld_q;
	logic [PIX_W-1:0]     store_mem [MAX_HEIGHT];

	logic                 out_valid_q;
	logic [GRP_W-1:0]     out_grp_q;
	logic [CNT_W-1:0]     out_cnt_q;
	logic [COL_W-1:0]     out_col_q;
	logic [ROW_W-1:0]     out_row_q;
	logic                 out_last_q;
	logic                 out_done_q;

	// byte decode
	logic                 in_acc;
	logic [LEN_W-1:0]     b;
	logic                 fin_e;
	logic                 await_e;
	logic [COL_W-1:0]     col_e;
	logic                 past_end;
	logic [LEN_W-1:0]     dec_len;
	logic                 dec_copy;
	logic [PIX_W-1:0]     dec_colour;
	logic                 dec_prefix;
	logic                 out_free;
	logic                 out_load;

	// pixel step
	logic [PIX_W-1:0]     pix;
	logic [GRP_W-1:0]     grp_base;
	logic [GRP_W-1:0]     grp_nx;
	logic [CNT_W-1:0]     cnt_nx;
	logic [ROW_W:0]       row_inc;
	logic [COL_W:0]       col_inc;
	logic                 wrap;
	logic                 col_end;
	logic [ROW_W-1:0]     row_nx;
	logic [COL_W-1:0]     col_nx;
	logic [LEN_W-1:0]     len_nx;
	logic                 run_end;
	logic                 emit;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_EMIT) && out_free;

	always_comb begin
		b        = code_byte ^ CODE_INVERT;
		fin_e    = image_start ? 1'b0 : fin_q;
		await_e  = image_start ? 1'b0 : await_q;
		col_e    = image_start ? '0 : col_q;
		past_end = ({1'b0, col_e} >= width_q);
		dec_prefix = 1'b0;
		if (await_e) begin
			dec_len    = b;
			dec_copy   = pend_copy_q;
			dec_colour = pend_colour_q;
		end else if (b < COPY_FLAG) begin
			dec_len    = {5'd0, b[6:4]};
			dec_copy   = 1'b0;
			dec_colour = b[3:0] & NIBBLE_MASK;
			dec_prefix = (b[6:4] == 3'd0);
		end else begin
			dec_len    = b & COPY_LEN;
			dec_copy   = 1'b1;
			dec_colour = '0;
			dec_prefix = ((b & COPY_LEN) == '0);
		end
	end

	always_comb begin
		if (copy_q) begin
			pix = (col_q == '0 || !store_vld_q[row_q]) ? '0 : rd_data_q;
		end else begin
			pix = colour_q;
		end
		grp_base = (cnt_q == '0) ? '0 : grp_q;
		grp_nx   = grp_base | (GRP_W'(pix) << {cnt_q[1:0], 2'b00});
		cnt_nx   = cnt_q + 1'b1;
		row_inc  = {1'b0, row_q} + 1'b1;
		col_inc  = {1'b0, col_q} + 1'b1;
		wrap     = (row_inc >= height_q);
		col_end  = wrap && (col_inc >= width_q);
		row_nx   = wrap ? '0 : row_inc[ROW_W-1:0];
		col_nx   = col_end ? '0 : (wrap ? col_inc[COL_W-1:0] : col_q);
		len_nx   = len_q - 1'b1;
		run_end  = (len_nx == '0) || col_end;
		emit     = (cnt_nx == CNT_W'(GRP_PIX)) || run_end;
	end

	// left-column store: read in ST_READ, written in ST_PIXEL
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_data_q <= store_mem[row_q];
		end
		if (state_q == ST_PIXEL) begin
			store_mem[row_q] <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			width_q       <= WIDTH_RESET;
			height_q      <= HEIGHT_RESET;
			await_q       <= 1'b0;
			pend_copy_q   <= 1'b0;
			pend_colour_q <= '0;
			col_q         <= '0;
			row_q         <= '0;
			fin_q         <= 1'b0;
			len_q         <= '0;
			copy_q        <= 1'b0;
			colour_q      <= '0;
			grp_q         <= '0;
			cnt_q         <= '0;
			gcol_q        <= '0;
			grow_q        <= '0;
			emit_last_q   <= 1'b0;
			emit_done_q   <= 1'b0;
			store_vld_q   <= '0;
			out_valid_q   <= 1'b0;
			out_grp_q     <= '0;
			out_cnt_q     <= '0;
			out_col_q     <= '0;
			out_row_q     <= '0;
			out_last_q    <= 1'b0;
			out_done_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH: begin
						if (cfg_wdata[WREG_W-1:0] == '0) begin
							width_q <= WREG_W'(1);
						end else if (cfg_wdata[WREG_W-1:0] > MAX_W_V) begin
							width_q <= MAX_W_V;
						end else begin
							width_q <= cfg_wdata[WREG_W-1:0];
						end
					end
					REG_IMAGE_HEIGHT: begin
						if (cfg_wdata[HREG_W-1:0] == '0) begin
							height_q <= HREG_W'(1);
						end else if (cfg_wdata[HREG_W-1:0] > MAX_H_V) begin
							height_q <= MAX_H_V;
						end else begin
							height_q <= cfg_wdata[HREG_W-1:0];
						end
					end
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (image_start) begin
							col_q <= '0;
							row_q <= '0;
						end
						fin_q <= fin_e || past_end;
						if (!fin_e && !past_end) begin
							if (dec_prefix) begin
								await_q       <= 1'b1;
								pend_copy_q   <= dec_copy;
								pend_colour_q <= dec_colour;
							end else begin
								await_q <= 1'b0;
								if (image_start) begin
									pend_copy_q   <= 1'b0;
									pend_colour_q <= '0;
								end
								if (dec_len != '0) begin
									len_q    <= dec_len;
									copy_q   <= dec_copy;
									colour_q <= dec_colour;
									cnt_q    <= '0;
									state_q  <= dec_copy ? ST_READ : ST_PIXEL;
								end
							end
						end
					end
				end
				ST_READ: begin
					state_q <= ST_PIXEL;
				end
				ST_PIXEL: begin
					store_vld_q[row_q] <= 1'b1;
					grp_q <= grp_nx;
					cnt_q <= cnt_nx;
					if (cnt_q == '0) begin
						gcol_q <= col_q;
						grow_q <= row_q;
					end
					row_q <= row_nx;
					col_q <= col_nx;
					if (col_end) begin
						fin_q <= 1'b1;
					end
					len_q       <= len_nx;
					emit_last_q <= run_end;
					emit_done_q <= col_end;
					if (emit) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= copy_q ? ST_READ : ST_PIXEL;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_grp_q   <= grp_q;
						out_cnt_q   <= cnt_q;
						out_col_q   <= gcol_q;
						out_row_q   <= grow_q;
						out_last_q  <= emit_last_q;
						out_done_q  <= emit_done_q;
						cnt_q       <= '0;
						if (emit_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= copy_q ? ST_READ : ST_PIXEL;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_group  = out_grp_q;
	assign pixel_count  = out_cnt_q;
	assign start_column = out_col_q;
	assign start_row    = out_row_q;
	assign last_of_run  = out_last_q;
	assign image_done   = out_done_q;

	// a group that does not end its byte is always full
	a_full_unless_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> pixel_count == CNT_W'(GRP_PIX))
		else $error("partial group without last_of_run");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_count != '0 && pixel_count <= CNT_W'(GRP_PIX))
		else $error("pixel_count out of range");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> last_of_run)
		else $error("image_done without last_of_run");

	// after the closing group the sequencer is back to taking bytes
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && out_free && emit_done_q |=> !in_stall && fin_q)
		else $error("sequencer busy after image end");

endmodule

// ===== tb/sv/column_rle_backdrop_decoder_checker.sv =====
`timescale 1ns / 1ps
module column_rle_backdrop_decoder_checker
	import crbd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [7:0]       code_byte,
	input  logic             image_start,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [GRP_W-1:0] pixel_group,
	input  logic [CNT_W-1:0] pixel_count,
	input  logic [COL_W-1:0] start_column,
	input  logic [ROW_W-1:0] start_row,
	input  logic             last_of_run,
	input  logic             image_done,
	output int               fail_count,
	output int               groups_due,
	output int               bytes_decoded
);

	typedef struct packed {
		logic [GRP_W-1:0] pixels;
		logic [CNT_W-1:0] count;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
		logic             done;
	} pixel_group_t;

	logic [WREG_W-1:0] width_reg;
	logic [HREG_W-1:0] height_reg;
	logic              want_len;
	logic              want_copy;
	logic [PIX_W-1:0]  held_colour;
	int unsigned       col_pos;
	int unsigned       row_pos;
	logic [PIX_W-1:0]  left_col [MAX_HEIGHT];
	logic              img_done;
	pixel_group_t      due_q [$];

	function automatic int unsigned eff_width();
		if (width_reg == '0) return 1;
		return (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg == '0) return 1;
		return (int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
	endfunction

	// expands one coded byte into the pixel groups it must produce
	task automatic decode_byte_groups(input logic [7:0] code, input logic start);
		int unsigned  w, h, len, z, cnt, idx;
		logic [7:0]   b;
		logic         copy;
		logic [PIX_W-1:0] colour, pix;
		pixel_group_t grp, held;
		logic         have_held;
		w = eff_width();
		h = eff_height();
		cnt = 0;
		grp = '0;
		held = '0;
		have_held = 1'b0;
		if (start) begin
			want_len = 1'b0;
			want_copy = 1'b0;
			held_colour = '0;
			col_pos = 0;
			row_pos = 0;
			img_done = 1'b0;
		end
		if (img_done) return;
		if (col_pos >= w) begin
			img_done = 1'b1;
			return;
		end
		bytes_decoded++;
		b = code ^ CODE_INVERT;
		if (want_len) begin
			want_len = 1'b0;
			len = b;
			copy = want_copy;
			colour = held_colour;
		end else if (b < COPY_FLAG) begin
			len = b[6:4];
			colour = b[3:0];
			copy = 1'b0;
			if (len == 0) begin
				// length comes in the next byte
				want_len = 1'b1;
				want_copy = 1'b0;
				held_colour = colour;
				return;
			end
		end else begin
			len = b & COPY_LEN;
			colour = '0;
			copy = 1'b1;
			if (len == 0) begin
				want_len = 1'b1;
				want_copy = 1'b1;
				held_colour = '0;
				return;
			end
		end
		for (z = 0; z < len && !img_done; z++) begin
			idx = (row_pos < MAX_HEIGHT) ? row_pos : 0;
			if (copy)
				pix = (col_pos == 0) ? '0 : left_col[idx];
			else
				pix = colour & NIBBLE_MASK;
			left_col[idx] = pix;
			if (cnt == 0) begin
				grp.pixels = '0;
				grp.col = COL_W'(col_pos);
				grp.row = ROW_W'(row_pos);
			end
			grp.pixels[PIX_W*cnt +: PIX_W] = pix;
			cnt++;
			row_pos++;
			if (row_pos >= h) begin
				row_pos = 0;
				col_pos++;
				if (col_pos >= w) begin
					img_done = 1'b1;
					col_pos = 0;
				end
			end
			if (cnt == GRP_PIX || img_done) begin
				grp.count = CNT_W'(cnt);
				grp.done = img_done;
				grp.last = 1'b0;
				if (have_held) due_q.push_back(held);
				held = grp;
				have_held = 1'b1;
				cnt = 0;
			end
		end
		if (cnt > 0) begin
			grp.count = CNT_W'(cnt);
			grp.done = 1'b0;
			grp.last = 1'b0;
			if (have_held) due_q.push_back(held);
			held = grp;
			have_held = 1'b1;
		end
		// final group of the byte carries the run mark
		if (have_held) begin
			held.last = 1'b1;
			due_q.push_back(held);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_group_t seen, want;
		if (!arst_n) begin
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			want_len = 1'b0;
			want_copy = 1'b0;
			held_colour = '0;
			col_pos = 0;
			row_pos = 0;
			img_done = 1'b0;
			foreach (left_col[i]) left_col[i] = '0;
			due_q.delete();
			fail_count = 0;
			groups_due = 0;
			bytes_decoded = 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = '{pixel_group, pixel_count, start_column, start_row,
					last_of_run, image_done};
				if (due_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected group: pixels %h count %0d col %0d row %0d",
							seen.pixels, seen.count, seen.col, seen.row);
				end else begin
					want = due_q.pop_front();
					if (seen !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"group mismatch: expected pixels %h count %0d col %0d ",
								"row %0d last %b done %b, got pixels %h count %0d col %0d ",
								"row %0d last %b done %b"},
								want.pixels, want.count, want.col, want.row, want.last,
								want.done, seen.pixels, seen.count, seen.col, seen.row,
								seen.last, seen.done);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_IMAGE_WIDTH: begin
						width_reg = cfg_wdata[WREG_W-1:0];
					end
					REG_IMAGE_HEIGHT: begin
						height_reg = cfg_wdata[HREG_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall)
				decode_byte_groups(code_byte, image_start);
			groups_due = due_q.size();
		end
	end

endmodule

// ===== tb/sv/column_rle_backdrop_decoder_top_tb.sv =====
`timescale 1ns / 1ps
module column_rle_backdrop_decoder_top_tb;
	import crbd_pkg::*;

	localparam int GAP_MAX       = 15;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_AFTER    = 100;
	localparam int RANDOM_BYTES  = 250;
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 40;
	localparam int STALL_LIMIT   = 5000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	logic             in_valid;
	logic             in_stall;
	logic [7:0]       code_byte;
	logic             image_start;
	logic             out_valid;
	logic             out_stall;
	logic [GRP_W-1:0] pixel_group;
	logic [CNT_W-1:0] pixel_count;
	logic [COL_W-1:0] start_column;
	logic [ROW_W-1:0] start_row;
	logic             last_of_run;
	logic             image_done;

	int fail_count;
	int groups_due;
	int bytes_decoded;
	int idle_cycles = 0;
	bit no_idle = 1'b0;
	bit hold_request = 1'b0;

	column_rle_backdrop_decoder_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.code_byte    (code_byte),
		.image_start  (image_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_group  (pixel_group),
		.pixel_count  (pixel_count),
		.start_column (start_column),
		.start_row    (start_row),
		.last_of_run  (last_of_run),
		.image_done   (image_done)
	);

	column_rle_backdrop_decoder_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.code_byte     (code_byte),
		.image_start   (image_start),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_group   (pixel_group),
		.pixel_count   (pixel_count),
		.start_column  (start_column),
		.start_row     (start_row),
		.last_of_run   (last_of_run),
		.image_done    (image_done),
		.fail_count    (fail_count),
		.groups_due    (groups_due),
		.bytes_decoded (bytes_decoded)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// takes the decoded form of a byte and sends its inverted code
	task automatic send_run(input logic [7:0] run, input logic start);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		code_byte <= run ^ CODE_INVERT;
		image_start <= start;
		do @(posedge clk); while (!(in_valid && !in_stall));
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// drain all outstanding groups, then let a lone prefix byte finish
	task automatic settle();
		in_valid <= 1'b0;
		while (groups_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic int unsigned pick_length(input int unsigned max_len);
		if ($urandom_range(0, 3) == 0) return $urandom_range(1, max_len);
		return $urandom_range(1, 10);
	endfunction

	task automatic random_image();
		int unsigned n_runs, k, kind;
		logic        first;
		logic [7:0]  run;
		first = 1'b1;
		n_runs = $urandom_range(2, 14);
		for (k = 0; k < n_runs; k++) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				run = {1'b0, 3'($urandom_range(1, 7)), 4'($urandom)};
			end else if (kind < 65) begin
				run = {1'b1, 7'(pick_length(127))};
			end else if (kind < 85) begin
				send_run($urandom_range(0, 1) ? COPY_FLAG : {4'h0, 4'($urandom)}, first);
				first = 1'b0;
				run = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'(pick_length(255));
			end else begin
				// noise, sometimes restarting the image midway
				run = 8'($urandom);
				if ($urandom_range(0, 7) == 0) first = 1'b1;
			end
			send_run(run, first);
			first = 1'b0;
		end
	endtask

	initial begin : stimulus
		int          base;
		int unsigned phase_w, phase_h, sel;
		cfg_we = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_wdata = '0;
		in_valid = 1'b0;
		code_byte = '0;
		image_start = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// 3x5 image: colour run across a column, copy, prefixes, overrun, bytes after done
		write_reg(REG_IMAGE_WIDTH, 3);
		write_reg(REG_IMAGE_HEIGHT, 5);
		send_run(8'h7A, 1'b1);
		send_run(8'h85, 1'b0);
		send_run(8'h03, 1'b0);
		send_run(8'h00, 1'b0);
		send_run(8'h80, 1'b0);
		send_run(8'h02, 1'b0);
		send_run(8'h7F, 1'b0);
		send_run(8'h11, 1'b0);
		send_run(8'h83, 1'b1);
		send_run(8'hFF, 1'b0);
		settle();

		// zero registers act as a single pixel
		write_reg(REG_IMAGE_WIDTH, 0);
		write_reg(REG_IMAGE_HEIGHT, 0);
		send_run(8'h1C, 1'b1);
		send_run(8'h00, 1'b0);
		send_run(8'hFF, 1'b1);
		settle();

		// oversize registers saturate; longest extended runs
		write_reg(REG_IMAGE_WIDTH, 12'hFFF);
		write_reg(REG_IMAGE_HEIGHT, 12'hFFF);
		send_run(8'h0C, 1'b1);
		send_run(8'hFF, 1'b0);
		send_run(8'h80, 1'b0);
		send_run(8'hFF, 1'b0);
		settle();

		// height shrunk below the current row, then width below the current column
		write_reg(REG_IMAGE_HEIGHT, 100);
		send_run(8'h12, 1'b0);
		send_run(8'h35, 1'b0);
		settle();
		write_reg(REG_IMAGE_WIDTH, 2);
		send_run(8'h11, 1'b0);
		send_run(8'h4A, 1'b0);

		base = bytes_decoded;
		while (bytes_decoded - base < RANDOM_BYTES) begin
			settle();
			sel = $urandom_range(0, 9);
			if (sel < 7) begin
				phase_w = $urandom_range(1, 8);
				phase_h = $urandom_range(1, 16);
			end else if (sel < 9) begin
				phase_w = $urandom_range(1, MAX_WIDTH);
				phase_h = $urandom_range(1, MAX_HEIGHT);
			end else begin
				case ($urandom_range(0, 3))
					0: phase_w = 0;
					1: phase_w = 1;
					2: phase_w = MAX_WIDTH;
					default: phase_w = 12'hFFF;
				endcase
				case ($urandom_range(0, 3))
					0: phase_h = 0;
					1: phase_h = 1;
					2: phase_h = MAX_HEIGHT;
					default: phase_h = 12'hFFF;
				endcase
			end
			write_reg(REG_IMAGE_WIDTH, phase_w);
			write_reg(REG_IMAGE_HEIGHT, phase_h);
			no_idle = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3)) begin
				if (bytes_decoded - base >= HOLD_AFTER) hold_request = 1'b1;
				random_image();
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0 && groups_due == 0)
			$display("column_rle_backdrop_decoder_top verification clean");
		else
			$display("column_rle_backdrop_decoder_top verification failed");
		$finish;
	end

	initial begin : receiver
		int unsigned hold;
		bit          hold_taken;
		out_stall = 1'b0;
		hold_taken = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			// one long hold-off lets the block back up into its input
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				hold = HOLD_CYCLES;
			end else begin
				hold = no_idle ? 0 : $urandom_range(0, GAP_MAX);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("column_rle_backdrop_decoder_top verification failed");
				$finish;
			end
		end
	end

endmodule

// ===== sim.f =====
hw/rtl/crbd_pkg.sv
hw/rtl/column_rle_backdrop_decoder_top.sv
tb/sv/column_rle_backdrop_decoder_checker.sv
tb/sv/column_rle_backdrop_decoder_top_tb.sv
